/* rtl/core/piecewise_linear_interp_assert.svh */
// Assertion macros for the piecewise linear interpolator checker.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef PIECEWISE_LINEAR_INTERP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define PLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pli_pkg.sv */
// Shared types and constants for the piecewise linear interpolator.
// Used by the sequencer, the divider and the top level; no dependencies.
package pli_pkg;

  // Fixed field widths
  localparam int DATA_W     = 32;
  localparam int DIFF_W     = DATA_W + 1;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = DATA_W + DIFF_W;
  localparam int OFF_W      = PROD_W - FRAC_W;
  localparam int SUM_W      = OFF_W + 1;
  localparam int IDX_W      = 4;
  localparam int CFG_W      = 5;
  localparam int APB_W      = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  // Divider widths: |dy| * 2^16 over |dx|
  localparam int NUM_W  = DIFF_W + FRAC_W;
  localparam int DEN_W  = DIFF_W;
  localparam int QCNT_W = $clog2(NUM_W);

  localparam int ROUND_HALF = 32768;
  localparam int MIN_POINTS = 2;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_POINTS_IN_USE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_LO_RD,
    ST_LO_LATCH,
    ST_SLOPE,
    ST_DIV,
    ST_MUL,
    ST_RND,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    RD_SEG_HI,
    RD_SCAN_HI,
    RD_SEG_LO
  } rd_sel_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic query_acc;
    logic fresh;
    logic beyond_hi;
    logic srch_hit;
    logic dx_zero;
    logic div_done;
    logic out_free;
  } sts_t;

  // Controls from the sequencer to the datapath
  typedef struct packed {
    logic    idle;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    scan_clr;
    logic    scan_inc;
    logic    seg_load;
    logic    lo_load;
    logic    slope_clr;
    logic    div_start;
    logic    slope_load;
    logic    mul_en;
    logic    rnd_en;
    logic    out_load;
  } ctl_t;

endpackage

/* rtl/core/pli_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

/* rtl/core/pli_div.sv */
// Restoring shift-subtract divider for the segment slope, one bit a cycle.
// Depends on pli_pkg for widths.
module pli_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [pli_pkg::DIFF_W-1:0] dy,
  input  logic signed [pli_pkg::DIFF_W-1:0] dx,
  output logic                              done_r,
  output logic signed [pli_pkg::DATA_W-1:0] slope
);

  localparam logic [pli_pkg::NUM_W-1:0] POS_MAX =
    pli_pkg::NUM_W'((64'd1 << (pli_pkg::DATA_W - 1)) - 64'd1);
  localparam logic [pli_pkg::NUM_W-1:0] NEG_MAX =
    pli_pkg::NUM_W'(64'd1 << (pli_pkg::DATA_W - 1));
  localparam logic [pli_pkg::DATA_W-1:0] SAT_HI =
    pli_pkg::DATA_W'((64'd1 << (pli_pkg::DATA_W - 1)) - 64'd1);
  localparam logic [pli_pkg::DATA_W-1:0] SAT_LO =
    pli_pkg::DATA_W'(64'd1 << (pli_pkg::DATA_W - 1));

  logic                              run_r;
  logic [pli_pkg::QCNT_W-1:0]        cnt_r;
  logic                              neg_r;
  logic [pli_pkg::NUM_W-1:0]         num_r;
  logic [pli_pkg::DEN_W-1:0]         den_r;
  logic [pli_pkg::DEN_W-1:0]         rem_r;
  logic [pli_pkg::DEN_W-1:0]         dy_mag;
  logic [pli_pkg::DEN_W-1:0]         dx_mag;
  logic [pli_pkg::DEN_W:0]           rem_sh;
  logic [pli_pkg::DEN_W:0]           trial;
  logic                              qbit;
  logic [pli_pkg::DATA_W-1:0]        mag_lo;

  // Magnitudes of the operands
  assign dy_mag = dy[pli_pkg::DIFF_W-1] ? pli_pkg::DEN_W'(-dy) : pli_pkg::DEN_W'(dy);
  assign dx_mag = dx[pli_pkg::DIFF_W-1] ? pli_pkg::DEN_W'(-dx) : pli_pkg::DEN_W'(dx);

  // One trial subtraction per cycle
  assign rem_sh = {rem_r, num_r[pli_pkg::NUM_W-1]};
  assign trial  = rem_sh - {1'b0, den_r};
  assign qbit   = !trial[pli_pkg::DEN_W];

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + pli_pkg::QCNT_W'(1);
        if (cnt_r == pli_pkg::QCNT_W'(pli_pkg::NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {dy_mag, pli_pkg::FRAC_W'(0)};
      den_r <= dx_mag;
      rem_r <= '0;
      neg_r <= dy[pli_pkg::DIFF_W-1] ^ dx[pli_pkg::DIFF_W-1];
    end else if (run_r) begin
      num_r <= {num_r[pli_pkg::NUM_W-2:0], qbit};
      rem_r <= qbit ? trial[pli_pkg::DEN_W-1:0] : rem_sh[pli_pkg::DEN_W-1:0];
    end
  end

  // Apply sign and clip to the Q16.16 range
  assign mag_lo = num_r[pli_pkg::DATA_W-1:0];

  always_comb begin
    if (neg_r) begin
      slope = (num_r > NEG_MAX) ? SAT_LO : -mag_lo;
    end else begin
      slope = (num_r > POS_MAX) ? SAT_HI : mag_lo;
    end
  end

endmodule

/* rtl/core/pli_seq.sv */
// Sequencer for the interpolator: search, slope division, multiply, round.
// Depends on pli_pkg for the state, status and control types.
module pli_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  pli_pkg::sts_t sts,
  output pli_pkg::ctl_t ctl
);

  pli_pkg::state_t state_r, state_nxt;
  logic            searched_r, searched_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pli_pkg::ST_IDLE;
      searched_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      searched_r <= searched_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt    = state_r;
    searched_nxt = searched_r;
    unique case (state_r)
      pli_pkg::ST_IDLE: begin
        if (sts.query_acc) begin
          state_nxt = sts.fresh ? pli_pkg::ST_SRCH_RD : pli_pkg::ST_CHK_RD;
        end
      end
      pli_pkg::ST_CHK_RD: state_nxt = pli_pkg::ST_CHK_CMP;
      pli_pkg::ST_CHK_CMP: begin
        if (sts.beyond_hi) begin
          state_nxt = pli_pkg::ST_SRCH_RD;
        end else begin
          state_nxt    = pli_pkg::ST_LO_RD;
          searched_nxt = 1'b0;
        end
      end
      pli_pkg::ST_SRCH_RD: state_nxt = pli_pkg::ST_SRCH_CMP;
      pli_pkg::ST_SRCH_CMP: begin
        if (sts.srch_hit) begin
          state_nxt    = pli_pkg::ST_LO_RD;
          searched_nxt = 1'b1;
        end else begin
          state_nxt = pli_pkg::ST_SRCH_RD;
        end
      end
      pli_pkg::ST_LO_RD: state_nxt = pli_pkg::ST_LO_LATCH;
      pli_pkg::ST_LO_LATCH: begin
        state_nxt = searched_r ? pli_pkg::ST_SLOPE : pli_pkg::ST_MUL;
      end
      pli_pkg::ST_SLOPE: begin
        state_nxt = sts.dx_zero ? pli_pkg::ST_MUL : pli_pkg::ST_DIV;
      end
      pli_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = pli_pkg::ST_MUL;
        end
      end
      pli_pkg::ST_MUL: state_nxt = pli_pkg::ST_RND;
      pli_pkg::ST_RND: state_nxt = pli_pkg::ST_FIN;
      pli_pkg::ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = pli_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pli_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    ctl        = '0;
    ctl.rd_sel = pli_pkg::RD_SEG_HI;
    unique case (state_r)
      pli_pkg::ST_IDLE: begin
        ctl.idle     = 1'b1;
        ctl.scan_clr = sts.query_acc && sts.fresh;
      end
      pli_pkg::ST_CHK_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = pli_pkg::RD_SEG_HI;
      end
      pli_pkg::ST_CHK_CMP: ctl.scan_clr = sts.beyond_hi;
      pli_pkg::ST_SRCH_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = pli_pkg::RD_SCAN_HI;
      end
      pli_pkg::ST_SRCH_CMP: begin
        ctl.seg_load = sts.srch_hit;
        ctl.scan_inc = !sts.srch_hit;
      end
      pli_pkg::ST_LO_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = pli_pkg::RD_SEG_LO;
      end
      pli_pkg::ST_LO_LATCH: ctl.lo_load = 1'b1;
      pli_pkg::ST_SLOPE: begin
        ctl.slope_clr = sts.dx_zero;
        ctl.div_start = !sts.dx_zero;
      end
      pli_pkg::ST_DIV: ctl.slope_load = sts.div_done;
      pli_pkg::ST_MUL: ctl.mul_en = 1'b1;
      pli_pkg::ST_RND: ctl.rnd_en = 1'b1;
      pli_pkg::ST_FIN: ctl.out_load = sts.out_free;
      default: ctl.idle = 1'b0;
    endcase
  end

endmodule

/* rtl/core/piecewise_linear_interp.sv */
// Piecewise linear interpolator over a breakpoint table, signed Q16.16.
// Load words are written to the table on acceptance. A query is tried on the cached
// segment unless it starts a batch or that segment lies past the table; then, or on a
// miss, a search and the 49-step slope divider run (no division for a zero span).
// Synchronous active-low reset clears control, segment, slope and register; the table
// holds undefined data until loaded.
module piecewise_linear_interp #(
  parameter int MAX_POINTS  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input words
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic [pli_pkg::IDX_W-1:0]             in_point_index,
  input  logic signed [pli_pkg::DATA_W-1:0]     in_point_x,
  input  logic signed [pli_pkg::DATA_W-1:0]     in_point_y,
  input  logic signed [pli_pkg::DATA_W-1:0]     in_sample_x,
  input  logic                                  in_first_of_batch,
  // Result words
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pli_pkg::DATA_W-1:0]     out_y_value,
  output logic [pli_pkg::IDX_W-1:0]             out_segment_used,
  output logic                                  out_saturated,
  output logic                                  out_zero_span,
  // Register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pli_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [pli_pkg::APB_W-1:0]             pwdata,
  output logic [pli_pkg::APB_W-1:0]             prdata,
  output logic                                  pready
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = ((AW > pli_pkg::CFG_W) ? AW : pli_pkg::CFG_W) + 1;
  localparam int RW = 2 * pli_pkg::DATA_W;
  localparam logic signed [pli_pkg::SUM_W-1:0] Y_MAX =
    pli_pkg::SUM_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [pli_pkg::SUM_W-1:0] Y_MIN = -Y_MAX - pli_pkg::SUM_W'(1);

  pli_pkg::ctl_t ctl;
  pli_pkg::sts_t sts;

  logic [pli_pkg::CFG_W-1:0]            points_r;
  logic [CW-1:0]                        cfg_n;
  logic [CW-1:0]                        n_use;
  logic                                 cfg_we;
  logic [pli_pkg::REG_IDX_W-1:0]        reg_idx;

  logic                                 in_acc;
  logic                                 load_we;
  logic [CW-1:0]                        load_idx;
  logic [AW-1:0]                        rd_addr;
  logic [CW-1:0]                        rd_idx;
  logic [RW-1:0]                        rd_data;
  logic signed [pli_pkg::DATA_W-1:0]    rd_x;
  logic signed [pli_pkg::DATA_W-1:0]    rd_y;

  logic signed [pli_pkg::DATA_W-1:0]    x_r;
  logic [CW-1:0]                        scan_r;
  logic [CW-1:0]                        seg_r;
  logic signed [pli_pkg::DATA_W-1:0]    hi_x_r;
  logic signed [pli_pkg::DATA_W-1:0]    hi_y_r;
  logic signed [pli_pkg::DIFF_W-1:0]    dx_r;
  logic signed [pli_pkg::DIFF_W-1:0]    dy_r;
  logic signed [pli_pkg::DIFF_W-1:0]    dxs_r;
  logic signed [pli_pkg::DATA_W-1:0]    lo_y_r;
  logic signed [pli_pkg::DATA_W-1:0]    slope_r;
  logic                                 zspan_r;
  logic signed [pli_pkg::PROD_W-1:0]    prod_r;
  logic signed [pli_pkg::PROD_W-1:0]    prod_w;
  logic signed [pli_pkg::PROD_W-1:0]    rnd_sum;
  logic signed [pli_pkg::OFF_W-1:0]     off_r;
  logic signed [pli_pkg::SUM_W-1:0]     y_sum;
  logic signed [pli_pkg::SUM_W-1:0]     y_sat;
  logic                                 y_clip;
  logic                                 div_done;
  logic signed [pli_pkg::DATA_W-1:0]    div_slope;

  logic                                 out_valid_r;
  logic signed [pli_pkg::DATA_W-1:0]    out_y_r;
  logic [pli_pkg::IDX_W-1:0]            out_seg_r;
  logic                                 out_sat_r;
  logic                                 out_zspan_r;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[pli_pkg::CFG_ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready
                   && (reg_idx == pli_pkg::REG_POINTS_IN_USE);
  assign prdata  = (reg_idx == pli_pkg::REG_POINTS_IN_USE) ? pli_pkg::APB_W'(points_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= pli_pkg::CFG_W'(pli_pkg::MIN_POINTS);
    end else if (cfg_we) begin
      points_r <= pwdata[pli_pkg::CFG_W-1:0];
    end
  end

  // Clamp the breakpoint count to the table
  assign cfg_n = CW'(points_r);

  always_comb begin
    if (cfg_n < CW'(pli_pkg::MIN_POINTS)) begin
      n_use = CW'(pli_pkg::MIN_POINTS);
    end else if (cfg_n > CW'(MAX_POINTS)) begin
      n_use = CW'(MAX_POINTS);
    end else begin
      n_use = cfg_n;
    end
  end

  // Input handshake and table writes
  assign in_stall = !ctl.idle;
  assign in_acc   = in_valid && !in_stall;
  assign load_idx = CW'(in_point_index);
  assign load_we  = in_acc && (in_kind == pli_pkg::KIND_LOAD) && (load_idx < CW'(MAX_POINTS));

  // Breakpoint table read address
  always_comb begin
    unique case (ctl.rd_sel)
      pli_pkg::RD_SEG_HI:  rd_idx = seg_r + CW'(1);
      pli_pkg::RD_SCAN_HI: rd_idx = scan_r + CW'(1);
      pli_pkg::RD_SEG_LO:  rd_idx = seg_r;
      default:             rd_idx = seg_r;
    endcase
  end

  assign rd_addr = rd_idx[AW-1:0];

  pli_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_POINTS)
  ) u_knots (
    .clk     (clk),
    .we      (load_we),
    .waddr   (load_idx[AW-1:0]),
    .wdata   ({in_point_x, in_point_y}),
    .re      (ctl.rd_en),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  assign rd_x = rd_data[RW-1:pli_pkg::DATA_W];
  assign rd_y = rd_data[pli_pkg::DATA_W-1:0];

  // Status for the sequencer
  assign sts.query_acc = in_acc && (in_kind == pli_pkg::KIND_QUERY);
  assign sts.fresh     = in_first_of_batch || ((seg_r + CW'(1)) >= n_use);
  assign sts.beyond_hi = x_r > rd_x;
  assign sts.srch_hit  = (x_r <= rd_x) || (scan_r == (n_use - CW'(pli_pkg::MIN_POINTS)));
  assign sts.dx_zero   = (dx_r == '0);
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || !out_stall;

  pli_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Hold the sample and walk the search index
  always_ff @(posedge clk) begin
    if (sts.query_acc) begin
      x_r <= in_sample_x;
    end
    if (ctl.scan_clr) begin
      scan_r <= '0;
    end else if (ctl.scan_inc) begin
      scan_r <= scan_r + CW'(1);
    end
  end

  // Segment, cached slope and zero-span flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r   <= '0;
      slope_r <= '0;
      zspan_r <= 1'b0;
    end else begin
      if (ctl.seg_load) begin
        seg_r <= scan_r;
      end
      if (ctl.slope_clr) begin
        slope_r <= '0;
        zspan_r <= 1'b1;
      end else if (ctl.slope_load) begin
        slope_r <= div_slope;
        zspan_r <= 1'b0;
      end
    end
  end

  // Capture segment end points and differences
  always_ff @(posedge clk) begin
    if (ctl.seg_load) begin
      hi_x_r <= rd_x;
      hi_y_r <= rd_y;
    end
    if (ctl.lo_load) begin
      dx_r   <= pli_pkg::DIFF_W'(hi_x_r) - pli_pkg::DIFF_W'(rd_x);
      dy_r   <= pli_pkg::DIFF_W'(hi_y_r) - pli_pkg::DIFF_W'(rd_y);
      dxs_r  <= pli_pkg::DIFF_W'(x_r) - pli_pkg::DIFF_W'(rd_x);
      lo_y_r <= rd_y;
    end
  end

  pli_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctl.div_start),
    .dy     (dy_r),
    .dx     (dx_r),
    .done_r (div_done),
    .slope  (div_slope)
  );

  // Multiply, then round to nearest at the binary point
  assign prod_w  = pli_pkg::PROD_W'(slope_r) * pli_pkg::PROD_W'(dxs_r);
  assign rnd_sum = prod_r + pli_pkg::PROD_W'(pli_pkg::ROUND_HALF);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_w;
    end
    if (ctl.rnd_en) begin
      off_r <= rnd_sum[pli_pkg::PROD_W-1:pli_pkg::FRAC_W];
    end
  end

  // Add the base and clip to the value range
  assign y_sum = pli_pkg::SUM_W'(lo_y_r) + pli_pkg::SUM_W'(off_r);

  always_comb begin
    if (y_sum > Y_MAX) begin
      y_sat  = Y_MAX;
      y_clip = 1'b1;
    end else if (y_sum < Y_MIN) begin
      y_sat  = Y_MIN;
      y_clip = 1'b1;
    end else begin
      y_sat  = y_sum;
      y_clip = 1'b0;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_y_r     <= y_sat[pli_pkg::DATA_W-1:0];
      out_seg_r   <= seg_r[pli_pkg::IDX_W-1:0];
      out_sat_r   <= y_clip;
      out_zspan_r <= zspan_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_y_value      = out_y_r;
  assign out_segment_used = out_seg_r;
  assign out_saturated    = out_sat_r;
  assign out_zero_span    = out_zspan_r;

endmodule

/* rtl/core/pli_checker.sv */
// Port-level checker for the piecewise linear interpolator, bound to the top.
// Depends on pli_pkg and the assertion macros header.
`include "piecewise_linear_interp_assert.svh"

module pli_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_kind,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [pli_pkg::DATA_W-1:0] out_y_value
);

  logic load_acc;
  logic query_acc;

  assign load_acc  = in_valid && !in_stall && (in_kind == pli_pkg::KIND_LOAD);
  assign query_acc = in_valid && !in_stall && (in_kind == pli_pkg::KIND_QUERY);

  // A load word never produces a result
  `PLI_ASSERT_NEXT(a_load_no_result, load_acc && !out_valid, !out_valid, "load word produced a result")

  // A query holds off further input while it is worked
  `PLI_ASSERT_NEXT(a_query_busy, query_acc, in_stall, "input taken while a query is in progress")

  // A query result never appears on the cycle after acceptance
  `PLI_ASSERT_NEXT(a_query_latency, query_acc && !out_valid, !out_valid, "query result too early")

  // A stalled result word holds
  `PLI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_y_value), "stalled result word changed")

endmodule

bind piecewise_linear_interp pli_checker u_pli_checker (.*);

/* sim/tb_piecewise_linear_interp.sv */
`timescale 1ns / 1ps
// Self-checking bench for piecewise_linear_interp: loads breakpoint tables, runs query
// batches under random idling on both channels and checks each result word in Q16.16.
// Depends on pli_pkg and the piecewise_linear_interp RTL.
module tb_piecewise_linear_interp;

  localparam int NUM_SLOTS     = 16;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int PHASE_WORDS   = 90;
  localparam int NUM_PHASES    = 10;
  localparam longint Y_MAX     = 64'sd2147483647;
  localparam longint Y_MIN     = -64'sd2147483648;

  typedef struct packed {
    logic                              kind;
    logic [pli_pkg::IDX_W-1:0]         index;
    logic signed [pli_pkg::DATA_W-1:0] px;
    logic signed [pli_pkg::DATA_W-1:0] py;
    logic signed [pli_pkg::DATA_W-1:0] sx;
    logic                              first;
  } word_t;

  typedef struct packed {
    logic signed [pli_pkg::DATA_W-1:0] y_value;
    logic [pli_pkg::IDX_W-1:0]         segment_used;
    logic                              saturated;
    logic                              zero_span;
  } sample_t;

  // Breakpoint table, cached segment and the results still owed by the block
  class interp_board;
    longint      knot_x [NUM_SLOTS];
    longint      knot_y [NUM_SLOTS];
    int unsigned segment;
    longint      slope;
    bit          flat;
    int unsigned points;
    int unsigned mismatches;
    sample_t     awaited [$];

    function new();
      foreach (knot_x[k]) begin
        knot_x[k] = 0;
        knot_y[k] = 0;
      end
      segment    = 0;
      slope      = 0;
      flat       = 0;
      points     = pli_pkg::MIN_POINTS;
      mismatches = 0;
    endfunction

    task report(string what);
      $display("MISMATCH %s", what);
      mismatches++;
    endtask

    // Apply an accepted word; a query queues the sample it must produce
    function void accept_word(word_t w);
      int unsigned n;
      int unsigned s;
      int          k;
      longint      x;
      longint      dx;
      longint      dy;
      longint      q;
      longint      y;
      sample_t     r;
      if (w.kind == pli_pkg::KIND_LOAD) begin
        knot_x[w.index] = $signed(w.px);
        knot_y[w.index] = $signed(w.py);
        return;
      end
      n = (points < pli_pkg::MIN_POINTS) ? pli_pkg::MIN_POINTS :
          ((points > NUM_SLOTS) ? NUM_SLOTS : points);
      x = $signed(w.sx);
      s = segment;
      // fresh search on a new batch, a stale segment or x past the upper knot
      if (w.first || s + 1 >= n || x > knot_x[s + 1]) begin
        s = n - 2;
        for (k = int'(n) - 2; k >= 0; k--)
          if (x <= knot_x[k + 1]) s = k;
        segment = s;
        dx = knot_x[s + 1] - knot_x[s];
        dy = knot_y[s + 1] - knot_y[s];
        if (dx == 0) begin
          slope = 0;
          flat  = 1;
        end else begin
          q = (dy * 65536) / dx;
          if (q > Y_MAX) q = Y_MAX;
          if (q < Y_MIN) q = Y_MIN;
          slope = q;
          flat  = 0;
        end
      end
      y = knot_y[s] + ((slope * (x - knot_x[s]) + pli_pkg::ROUND_HALF) >>> pli_pkg::FRAC_W);
      r.saturated = 1'b0;
      if (y > Y_MAX) begin
        y = Y_MAX;
        r.saturated = 1'b1;
      end
      if (y < Y_MIN) begin
        y = Y_MIN;
        r.saturated = 1'b1;
      end
      r.y_value      = y[pli_pkg::DATA_W-1:0];
      r.segment_used = s[pli_pkg::IDX_W-1:0];
      r.zero_span    = flat;
      awaited.insert(awaited.size(), r);
    endfunction

    // Compare a delivered sample with the oldest one owed
    task check_result(sample_t got);
      sample_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing pending: y_value=%0d segment_used=%0d",
                         got.y_value, got.segment_used));
        return;
      end
      want = awaited.pop_front();
      if (got.y_value !== want.y_value)
        report($sformatf("y_value %0d, expected %0d", got.y_value, want.y_value));
      if (got.segment_used !== want.segment_used)
        report($sformatf("segment_used %0d, expected %0d",
                         got.segment_used, want.segment_used));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated %b, expected %b", got.saturated, want.saturated));
      if (got.zero_span !== want.zero_span)
        report($sformatf("zero_span %b, expected %b", got.zero_span, want.zero_span));
    endtask
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic                              in_kind;
  logic [pli_pkg::IDX_W-1:0]         in_point_index;
  logic signed [pli_pkg::DATA_W-1:0] in_point_x;
  logic signed [pli_pkg::DATA_W-1:0] in_point_y;
  logic signed [pli_pkg::DATA_W-1:0] in_sample_x;
  logic                              in_first_of_batch;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [pli_pkg::DATA_W-1:0] out_y_value;
  logic [pli_pkg::IDX_W-1:0]         out_segment_used;
  logic                              out_saturated;
  logic                              out_zero_span;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [pli_pkg::CFG_ADDR_W-1:0]    paddr;
  logic [pli_pkg::APB_W-1:0]         pwdata;
  logic [pli_pkg::APB_W-1:0]         prdata;
  logic                              pready;

  interp_board board;
  bit          quiet;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned words_sent;
  longint      span_lo;
  longint      span_hi;
  int unsigned point_settings [NUM_PHASES] = '{16, 2, 31, 7, 1, 16, 0, 12, 17, 5};

  piecewise_linear_interp u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_point_index    (in_point_index),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_sample_x       (in_sample_x),
    .in_first_of_batch (in_first_of_batch),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_y_value       (out_y_value),
    .out_segment_used  (out_segment_used),
    .out_saturated     (out_saturated),
    .out_zero_span     (out_zero_span),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  // Abandon the run if the block stops making progress
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_piecewise_linear_interp NOT OK");
      $finish;
    end
  end

  // Check accepted result words; stall the result channel in random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(sample_t'{out_y_value, out_segment_used, out_saturated,
                                   out_zero_span});
    if (quiet || !rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic signed [pli_pkg::DATA_W-1:0] clamp32(longint v);
    if (v > Y_MAX) return 32'sh7FFFFFFF;
    if (v < Y_MIN) return 32'sh80000000;
    return v[pli_pkg::DATA_W-1:0];
  endfunction

  function automatic logic signed [pli_pkg::DATA_W-1:0] random_y();
    return $signed($urandom) >>> $urandom_range(0, 12);
  endfunction

  function automatic int unsigned idle_gap();
    if (quiet || $urandom_range(0, 7) != 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  function automatic word_t make_load(logic [pli_pkg::IDX_W-1:0] index,
                                      logic signed [pli_pkg::DATA_W-1:0] x,
                                      logic signed [pli_pkg::DATA_W-1:0] y);
    word_t w;
    w.kind  = pli_pkg::KIND_LOAD;
    w.index = index;
    w.px    = x;
    w.py    = y;
    w.sx    = $urandom;
    w.first = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic word_t make_query(logic signed [pli_pkg::DATA_W-1:0] x, logic first);
    word_t w;
    w.kind  = pli_pkg::KIND_QUERY;
    w.index = pli_pkg::IDX_W'($urandom);
    w.px    = $urandom;
    w.py    = $urandom;
    w.sx    = x;
    w.first = first;
    return w;
  endfunction

  // Present one word, hold it until accepted, then hand it to the board
  task automatic send_word(word_t w);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_kind           <= w.kind;
    in_point_index    <= w.index;
    in_point_x        <= w.px;
    in_point_y        <= w.py;
    in_sample_x       <= w.sx;
    in_first_of_batch <= w.first;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.accept_word(w);
    words_sent++;
  endtask

  // Drop valid, wait for every owed result, then let a trailing load finish
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_points(int unsigned value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {pli_pkg::REG_POINTS_IN_USE, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.points = value & 5'h1F;
  endtask

  // Load slots 0..n-1 with non-decreasing x at a random scale
  task automatic load_table(int unsigned n);
    longint      xv;
    longint      step_max;
    int unsigned k;
    case ($urandom_range(0, 3))
      0:       step_max = 64'sd1 << 18;
      1:       step_max = 64'sd1 << 26;
      2:       step_max = 64'sd1 << 31;
      default: step_max = 4;
    endcase
    xv = -(step_max * longint'(n)) / 2 + longint'($urandom_range(0, 65535)) - 32768;
    span_lo = $signed(clamp32(xv));
    for (k = 0; k < n; k++) begin
      send_word(make_load(k[pli_pkg::IDX_W-1:0], clamp32(xv), random_y()));
      span_hi = $signed(clamp32(xv));
      if ($urandom_range(0, 9) != 0) xv += longint'($urandom_range(0, 32'(step_max)));
    end
  endtask

  // One batch: fresh search first, then mostly rising x with the odd step back
  task automatic run_batch(int unsigned len, int unsigned n);
    longint      xv;
    longint      stride;
    int unsigned i;
    stride = (span_hi - span_lo) / longint'(len) + 1;
    if (stride < 1) stride = 1;
    if (stride > (64'sd1 << 30)) stride = 64'sd1 << 30;
    xv = span_lo - longint'($urandom_range(0, 32'(stride * 2)));
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 24) == 0)
        send_word(make_load(4'($urandom_range(0, n - 1)), clamp32(xv), random_y()));
      send_word(make_query(clamp32(xv), i == 0));
      if ($urandom_range(0, 9) == 0) xv -= longint'($urandom_range(0, 32'(stride)));
      else xv += longint'($urandom_range(0, 32'(stride * 2)));
    end
  endtask

  initial begin
    int unsigned ph;
    int unsigned n_eff;
    int unsigned phase_start;
    int unsigned pick;
    int unsigned len;
    board             = new();
    clk               = 1'b0;
    rst_n             = 1'b0;
    quiet             = 1'b0;
    stall_left        = 0;
    cycle_count       = 0;
    words_sent        = 0;
    span_lo           = 0;
    span_hi           = 0;
    in_valid          = 1'b0;
    in_kind           = pli_pkg::KIND_LOAD;
    in_point_index    = '0;
    in_point_x        = '0;
    in_point_y        = '0;
    in_sample_x       = '0;
    in_first_of_batch = 1'b0;
    out_stall         = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Four knots: a zero-span bottom segment, then two steep ones
    write_points(4);
    send_word(make_load(pli_pkg::IDX_W'(0), -32'sh10000, 32'sh7FFFFFFF));
    send_word(make_load(pli_pkg::IDX_W'(1), -32'sh10000, 32'sh80000000));
    send_word(make_load(pli_pkg::IDX_W'(2), 32'sh10000, 32'sh0));
    send_word(make_load(pli_pkg::IDX_W'(3), 32'sh20000, 32'sh40000000));
    send_word(make_query(32'sh80000000, 1'b1));
    send_word(make_query(32'sh0, 1'b0));
    // past the last knot clips high; a smaller x keeps that segment and clips low
    send_word(make_query(32'sh7FFFFFFF, 1'b0));
    send_word(make_query(32'sh80000000, 1'b0));
    send_word(make_query(32'sh18000, 1'b1));
    // reload a knot mid-batch: slope stays cached, the ends are read live
    send_word(make_load(pli_pkg::IDX_W'(3), 32'sh20000, 32'sh0));
    send_word(make_query(32'sh10000, 1'b0));
    send_word(make_query(32'sh1C000, 1'b0));
    send_word(make_query(32'sh1C000, 1'b1));
    // shrink the table under the cached segment
    drain_and_settle();
    write_points(2);
    send_word(make_query(32'sh5, 1'b0));
    // knots out of order
    send_word(make_load(pli_pkg::IDX_W'(1), -32'sh20000, 32'sh12345678));
    send_word(make_query(-32'sh18000, 1'b1));
    send_word(make_query(32'sh7FFF8000, 1'b0));

    // Random phases, each under its own table size, the last without idling
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_and_settle();
      quiet = (ph == NUM_PHASES - 1);
      write_points(point_settings[ph]);
      n_eff = (point_settings[ph] < pli_pkg::MIN_POINTS) ? pli_pkg::MIN_POINTS :
              ((point_settings[ph] > NUM_SLOTS) ? NUM_SLOTS : point_settings[ph]);
      phase_start = words_sent;
      load_table(n_eff);
      while (words_sent < phase_start + PHASE_WORDS) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_word(make_load(pli_pkg::IDX_W'($urandom), $urandom, $urandom));
        end else if (pick == 1) begin
          send_word(make_query($urandom, 1'($urandom_range(0, 1))));
        end else begin
          len = $urandom_range(3, 12);
          run_batch(len, n_eff);
        end
      end
    end

    drain_and_settle();
    if (board.mismatches == 0) begin
      $display("tb_piecewise_linear_interp OK");
    end else begin
      $display("tb_piecewise_linear_interp NOT OK");
    end
    $finish;
  end

endmodule

/* piecewise_linear_interp.f */
+incdir+rtl/core
rtl/core/pli_pkg.sv
rtl/core/pli_ram.sv
rtl/core/pli_div.sv
rtl/core/pli_seq.sv
rtl/core/piecewise_linear_interp.sv
rtl/core/pli_checker.sv
sim/tb_piecewise_linear_interp.sv
